// ===== src/l2ml_pkg.sv =====
// ----------------------------------------------------------------------------
// l2ml_pkg: shared definitions for the layer-2 mac learning table
// sizes, event and status codes, and the packed result item
// ----------------------------------------------------------------------------
`default_nettype none

package l2ml_pkg;

    // table geometry
    localparam int NUM_SWITCHES  = 4;
    localparam int TABLE_ENTRIES = 64;
    localparam int TOTAL_ENTRIES = NUM_SWITCHES * TABLE_ENTRIES;
    localparam int ADDR_W        = $clog2(TOTAL_ENTRIES);
    localparam int ENT_W         = $clog2(TABLE_ENTRIES);
    localparam int BANK_W        = (NUM_SWITCHES > 1) ? $clog2(NUM_SWITCHES) : 1;

    // field widths
    localparam int MAC_W  = 48;
    localparam int PORT_W = 32;
    localparam int PRIO_W = 31;
    localparam int STAT_W = 3;

    // stream widths
    localparam int IN_TDATA_W  = 136;
    localparam int IN_TUSER_W  = 2;
    localparam int RES_W       = 1 + PORT_W + 1 + PRIO_W + STAT_W;
    localparam int OUT_TDATA_W = 72;

    // constants
    localparam logic [MAC_W-1:0]  BCAST_MAC  = 48'hffff_ffff_ffff;
    localparam logic [PORT_W-1:0] FLOOD_PORT = 32'hffff_fffb;
    localparam logic [PRIO_W-1:0] PRIO_START = 31'd100;
    localparam logic [PRIO_W-1:0] PRIO_MAX   = 31'h7fff_ffff;

    // event kinds
    localparam logic [1:0] MODE_HANDSHAKE    = 2'd0;
    localparam logic [1:0] MODE_PACKET_IN    = 2'd1;
    localparam logic [1:0] MODE_FLOW_REMOVED = 2'd2;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STATUS_NO_BANK  = 3'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL     = 3'd2;
    localparam logic [STAT_W-1:0] STATUS_EXISTS   = 3'd3;
    localparam logic [STAT_W-1:0] STATUS_CONFLICT = 3'd4;
    localparam logic [STAT_W-1:0] STATUS_BAD_SRC  = 3'd5;

    // result item, send_packet in the lowest bit
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [PRIO_W-1:0] flow_priority;
        logic              install_flow;
        logic [PORT_W-1:0] out_port;
        logic              send_packet;
    } res_t;

endpackage

`default_nettype wire

// ===== src/l2_mac_learning_table_unit.sv =====
// ----------------------------------------------------------------------------
// l2_mac_learning_table_unit: per-switch mac learning table
// handshake, table-miss lookup/learn and flow-removed erase over one
// tag memory and one port memory, scanned one entry per cycle
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  s_axis    in   s_tvalid/s_tready  s_tdata (event fields), s_tuser (mode)
//  m_axis    out  m_tvalid/m_tready  m_tdata (result fields)
//
// handshakes, unknown events, non-miss packets and missing banks skip the
// scan. a table-miss packet-in or a flow-removed on an enabled bank scans the
// bank, one memory word per cycle, through the single read port of the
// tag and port memories.
// reset clears the entry valid flags and the bank enables and sets the
// priority counter to PRIO_START at once; no clearing pass is needed.
// one event is worked on at a time; a new event is taken while a finished
// result still waits in the output register.
//
`default_nettype none

module l2_mac_learning_table_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // switch_index, miss_reason, in_port, src_mac, dst_mac, zero pad
    input  wire logic [l2ml_pkg::IN_TDATA_W-1:0] s_tdata,
    // mode
    input  wire logic [l2ml_pkg::IN_TUSER_W-1:0] s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // send_packet, out_port, install_flow, flow_priority, status, zero pad
    output logic [l2ml_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_TAIL,
        S_COMMIT,
        S_DONE
    } state_t;

    // control and event registers
    state_t                         state_reg;
    logic [l2ml_pkg::NUM_SWITCHES-1:0]  bank_ready_reg;
    logic [l2ml_pkg::TOTAL_ENTRIES-1:0] valid_reg;
    logic [l2ml_pkg::PRIO_W-1:0]    prio_reg;
    logic [l2ml_pkg::PRIO_W-1:0]    prio_next;
    logic [1:0]                     mode_reg;
    logic [l2ml_pkg::PORT_W-1:0]    in_port_reg;
    logic [l2ml_pkg::MAC_W-1:0]     src_reg;
    logic [l2ml_pkg::MAC_W-1:0]     dst_reg;
    logic [l2ml_pkg::ADDR_W-1:0]    base_reg;
    logic [l2ml_pkg::ENT_W-1:0]     cnt_reg;
    logic [l2ml_pkg::ENT_W-1:0]     rd_idx_reg;
    logic                           rd_vld_reg;

    // input field views
    logic [1:0]                   in_mode;
    logic [1:0]                   in_switch;
    logic                         in_miss;
    logic [l2ml_pkg::PORT_W-1:0]  in_port_w;
    logic [l2ml_pkg::MAC_W-1:0]   in_src;
    logic [l2ml_pkg::MAC_W-1:0]   in_dst;
    logic [l2ml_pkg::BANK_W-1:0]  in_bank;
    logic                         in_sw_ok;
    logic                         in_have_bank;

    assign in_mode      = s_tuser;
    assign in_switch    = s_tdata[1:0];
    assign in_miss      = s_tdata[2];
    assign in_port_w    = s_tdata[34:3];
    assign in_src       = s_tdata[82:35];
    assign in_dst       = s_tdata[130:83];
    assign in_bank      = l2ml_pkg::BANK_W'(in_switch);
    assign in_sw_ok     = (32'(in_switch) < l2ml_pkg::NUM_SWITCHES);
    assign in_have_bank = in_sw_ok && bank_ready_reg[in_bank];

    // scan results
    logic                           dst_hit_reg;
    logic [l2ml_pkg::ENT_W-1:0]     dst_idx_reg;
    logic [l2ml_pkg::PORT_W-1:0]    dst_port_reg;
    logic                           src_hit_reg;
    logic [l2ml_pkg::PORT_W-1:0]    src_port_reg;
    logic                           free_hit_reg;
    logic [l2ml_pkg::ENT_W-1:0]     free_idx_reg;

    l2ml_pkg::res_t                 res_reg;
    l2ml_pkg::res_t                 m_res_reg;
    logic                           m_tvalid_reg;

    // memories and read data
    logic [l2ml_pkg::MAC_W-1:0]     tag_mem [l2ml_pkg::TOTAL_ENTRIES];
    logic [l2ml_pkg::PORT_W-1:0]    port_mem [l2ml_pkg::TOTAL_ENTRIES];
    logic [l2ml_pkg::MAC_W-1:0]     tag_q;
    logic [l2ml_pkg::PORT_W-1:0]    port_q;
    logic                           vld_q;

    logic [l2ml_pkg::ADDR_W-1:0]    rd_addr;
    logic [l2ml_pkg::ADDR_W-1:0]    free_addr;
    logic [l2ml_pkg::ADDR_W-1:0]    dst_addr;
    logic                           mem_we;
    logic                           learn;
    logic                           in_xfer;
    logic                           out_free;

    // outcome of an accepted event before any scan
    l2ml_pkg::res_t                 acc_res;
    logic                           acc_scan;
    logic                           acc_enable;

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(l2ml_pkg::OUT_TDATA_W - l2ml_pkg::RES_W){1'b0}}, m_res_reg};

    // entry addresses within the selected bank
    assign rd_addr   = base_reg + l2ml_pkg::ADDR_W'(cnt_reg);
    assign free_addr = base_reg + l2ml_pkg::ADDR_W'(free_idx_reg);
    assign dst_addr  = base_reg + l2ml_pkg::ADDR_W'(dst_idx_reg);

    // a new source is learned at commit when a free entry was found
    assign learn = (state_reg == S_COMMIT) && (mode_reg == l2ml_pkg::MODE_PACKET_IN)
                   && (src_reg != l2ml_pkg::BCAST_MAC) && !src_hit_reg && free_hit_reg;
    assign mem_we = learn;

    // saturating priority step
    assign prio_next = (prio_reg < l2ml_pkg::PRIO_MAX) ? prio_reg + 1'b1 : prio_reg;

    // event decode at the input transfer
    always_comb
    begin
        acc_res    = '0;
        acc_scan   = 1'b0;
        acc_enable = 1'b0;
        unique case (in_mode)
            l2ml_pkg::MODE_HANDSHAKE:
            begin
                if (!in_sw_ok)
                begin
                    acc_res.status = l2ml_pkg::STATUS_NO_BANK;
                end
                else if (bank_ready_reg[in_bank])
                begin
                    acc_res.status = l2ml_pkg::STATUS_EXISTS;
                end
                else
                begin
                    acc_enable = 1'b1;
                end
            end
            l2ml_pkg::MODE_PACKET_IN:
            begin
                if (in_miss)
                begin
                    acc_res.send_packet = 1'b1;
                    acc_res.out_port    = l2ml_pkg::FLOOD_PORT;
                    if (!in_have_bank)
                    begin
                        acc_res.status = l2ml_pkg::STATUS_NO_BANK;
                    end
                    else
                    begin
                        acc_scan = 1'b1;
                    end
                end
            end
            l2ml_pkg::MODE_FLOW_REMOVED:
            begin
                if (!in_have_bank)
                begin
                    acc_res.status = l2ml_pkg::STATUS_NO_BANK;
                end
                else
                begin
                    acc_scan = 1'b1;
                end
            end
            default:
            begin
                // unknown event: all-zero result
            end
        endcase
    end

    // tag and port memories, one read and one write per cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tag_mem[free_addr]  <= src_reg;
            port_mem[free_addr] <= in_port_reg;
        end
        tag_q  <= tag_mem[rd_addr];
        port_q <= port_mem[rd_addr];
        vld_q  <= valid_reg[rd_addr];
    end

    // control, scan bookkeeping and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bank_ready_reg <= '0;
            valid_reg      <= '0;
            prio_reg       <= l2ml_pkg::PRIO_START;
            rd_vld_reg     <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            // output register loads a finished result and drains on a transfer
            if (state_reg == S_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end

            // compare the word read last cycle
            if (rd_vld_reg)
            begin
                if (vld_q && tag_q == dst_reg && !dst_hit_reg)
                begin
                    dst_hit_reg  <= 1'b1;
                    dst_idx_reg  <= rd_idx_reg;
                    dst_port_reg <= port_q;
                end
                if (vld_q && tag_q == src_reg && !src_hit_reg)
                begin
                    src_hit_reg  <= 1'b1;
                    src_port_reg <= port_q;
                end
                if (!vld_q && !free_hit_reg)
                begin
                    free_hit_reg <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
            rd_vld_reg <= (state_reg == S_SCAN);
            rd_idx_reg <= cnt_reg;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        mode_reg     <= in_mode;
                        in_port_reg  <= in_port_w;
                        src_reg      <= in_src;
                        dst_reg      <= in_dst;
                        base_reg     <= l2ml_pkg::ADDR_W'(in_bank)
                                        * l2ml_pkg::ADDR_W'(l2ml_pkg::TABLE_ENTRIES);
                        cnt_reg      <= '0;
                        dst_hit_reg  <= 1'b0;
                        src_hit_reg  <= 1'b0;
                        free_hit_reg <= 1'b0;
                        res_reg      <= acc_res;
                        state_reg    <= acc_scan ? S_SCAN : S_DONE;
                        if (acc_enable)
                        begin
                            bank_ready_reg[in_bank] <= 1'b1;
                        end
                    end
                end

                // issue one read per entry of the bank
                S_SCAN:
                begin
                    if (32'(cnt_reg) == l2ml_pkg::TABLE_ENTRIES - 1)
                    begin
                        state_reg <= S_TAIL;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end

                // last word compared this cycle
                S_TAIL:
                begin
                    state_reg <= S_COMMIT;
                end

                // decide the outcome and write back
                S_COMMIT:
                begin
                    state_reg <= S_DONE;
                    if (mode_reg == l2ml_pkg::MODE_FLOW_REMOVED)
                    begin
                        if (dst_hit_reg)
                        begin
                            valid_reg[dst_addr] <= 1'b0;
                        end
                    end
                    else
                    begin
                        if (dst_hit_reg && dst_reg != l2ml_pkg::BCAST_MAC)
                        begin
                            res_reg.out_port <= dst_port_reg;
                        end
                        if (src_reg == l2ml_pkg::BCAST_MAC)
                        begin
                            res_reg.status <= l2ml_pkg::STATUS_BAD_SRC;
                        end
                        else if (src_hit_reg)
                        begin
                            if (src_port_reg != in_port_reg)
                            begin
                                res_reg.status <= l2ml_pkg::STATUS_CONFLICT;
                            end
                        end
                        else if (!free_hit_reg)
                        begin
                            res_reg.status <= l2ml_pkg::STATUS_FULL;
                        end
                    end
                    if (learn)
                    begin
                        valid_reg[free_addr]  <= 1'b1;
                        prio_reg              <= prio_next;
                        res_reg.install_flow  <= 1'b1;
                        res_reg.flow_priority <= prio_next;
                    end
                end

                // hand the result to the output register
                S_DONE:
                begin
                    if (out_free)
                    begin
                        m_res_reg    <= res_reg;
                        state_reg    <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire
